/* rtl/ckpc_pkg.sv */
// Shared types, register map, format codes and conversion functions of the color-keyed converter.
package ckpc_pkg;

    localparam int PAL_DEPTH   = 256;
    localparam int PAL_WIDTH   = 24;
    localparam int PAL_AW      = 8;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef enum logic [1:0] {
        SRC_IDX8   = 2'd0,
        SRC_RGB565 = 2'd1,
        SRC_RGB24  = 2'd2,
        SRC_RGB32  = 2'd3
    } src_depth_t;

    typedef enum logic [1:0] {
        DST_RGB332 = 2'd0,
        DST_RGB565 = 2'd1,
        DST_RGB24  = 2'd2,
        DST_RGB32  = 2'd3
    } dst_depth_t;

    typedef enum logic [2:0] {
        REG_SRC_DEPTH  = 3'd0,
        REG_DST_DEPTH  = 3'd1,
        REG_KEY_ENABLE = 3'd2,
        REG_KEY_COLOR  = 3'd3,
        REG_COPY_INDEX = 3'd4
    } reg_index_t;

    typedef enum logic {
        KIND_PIXEL   = 1'b0,
        KIND_PAL_WR  = 1'b1
    } kind_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] pixel_value;
        logic [7:0]  pal_index;
        logic [23:0] pal_color;
        logic        last_in;
    } ckpc_in_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        write_enable;
        logic        last_out;
    } ckpc_out_t;

    typedef struct packed {
        src_depth_t  src_depth;
        dst_depth_t  dst_depth;
        logic        key_enable;
        logic [31:0] key_color;
        logic        copy_index;
    } ckpc_cfg_t;

    function automatic logic [23:0] widen565(input logic [15:0] c);
        return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
    endfunction

    function automatic logic [7:0] to_rgb332(input logic [23:0] c);
        return {c[23:21], c[15:13], c[7:6]};
    endfunction

    function automatic logic [15:0] to_rgb565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [7:0] narrow565(input logic [15:0] c);
        return {c[15:13], c[10:8], c[4:3]};
    endfunction

endpackage

/* rtl/color_keyed_pixel_converter_top.sv */
// Top level of the color-keyed pixel converter: three-stage pixel pipeline.
//
// Input beats on s_data either write one palette entry (kind 1) or carry one
// source pixel (kind 0). Each pixel beat yields exactly one result beat on
// m_data, in order: the pixel converted to the destination format, with
// write_enable clear (and out_pixel zero) when keying is on and the pixel
// equals the key color. Palette writes yield no result beat.
// The APB port sets source and destination formats, keying and index copy;
// write it only while no pixel is in flight.
// One beat is taken every cycle while the receiver does not stall. The 8-bit
// palette read sits in the first stage (registered RAM read), the channel mux
// in the second, the format packing and key override in the third.
// Each stage moves when it is empty or the next stage moves, so a stalled
// receiver fills the empty stages first and s_ready drops only once all
// three hold a pixel; nothing is dropped or repeated.
// Reset clears the stage valid bits and the stage registers, but not the palette
// read register; palette contents stay undefined until written.
module color_keyed_pixel_converter_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ckpc_pkg::ckpc_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ckpc_pkg::ckpc_out_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckpc_pkg::APB_AW-1:0] paddr,
    input  logic [ckpc_pkg::APB_DW-1:0] pwdata,
    output logic [ckpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ckpc_pkg::*;

    ckpc_cfg_t cfg;

    logic en1, en2, en3;
    logic in_fire, pix_fire, pal_fire;

    logic        v1_reg, v2_reg, v3_reg;
    logic [31:0] raw1_reg, raw2_reg;
    logic        match1_reg, match2_reg;
    logic        last1_reg, last2_reg;
    logic [23:0] rgb2_reg;
    ckpc_out_t   out3_reg;

    logic [31:0]          raw_in;
    logic [PAL_WIDTH-1:0] pal_rdata;
    logic [23:0]          rgb_next;
    logic [31:0]          res_next;

    ckpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign in_fire  = s_valid && s_ready;
    assign pix_fire = in_fire && (s_data.kind == KIND_PIXEL);
    assign pal_fire = in_fire && (s_data.kind == KIND_PAL_WR);

    ckpc_ram #(
        .WIDTH (PAL_WIDTH),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_fire),
        .waddr (s_data.pal_index),
        .wdata (s_data.pal_color),
        .re    (pix_fire),
        .raddr (s_data.pixel_value[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    always_comb begin
        case (cfg.src_depth)
            SRC_IDX8:   raw_in = {24'd0, s_data.pixel_value[7:0]};
            SRC_RGB565: raw_in = {16'd0, s_data.pixel_value[15:0]};
            SRC_RGB24:  raw_in = {8'd0, s_data.pixel_value[23:0]};
            default:    raw_in = s_data.pixel_value;
        endcase
    end

    always_comb begin
        case (cfg.src_depth)
            SRC_IDX8:   rgb_next = pal_rdata;
            SRC_RGB565: rgb_next = widen565(raw1_reg[15:0]);
            default:    rgb_next = raw1_reg[23:0];
        endcase
    end

    always_comb begin
        case (cfg.dst_depth)
            DST_RGB332: begin
                if (cfg.src_depth == SRC_IDX8 && cfg.copy_index) begin
                    res_next = {24'd0, raw2_reg[7:0]};
                end else if (cfg.src_depth == SRC_RGB565) begin
                    res_next = {24'd0, narrow565(raw2_reg[15:0])};
                end else begin
                    res_next = {24'd0, to_rgb332(rgb2_reg)};
                end
            end
            DST_RGB565: begin
                if (cfg.src_depth == SRC_RGB565) begin
                    res_next = {16'd0, raw2_reg[15:0]};
                end else begin
                    res_next = {16'd0, to_rgb565(rgb2_reg)};
                end
            end
            DST_RGB24: res_next = {8'd0, rgb2_reg};
            default: begin
                if (cfg.src_depth == SRC_RGB32) begin
                    res_next = raw2_reg;
                end else begin
                    res_next = {8'd0, rgb2_reg};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            raw1_reg   <= '0;
            raw2_reg   <= '0;
            match1_reg <= 1'b0;
            match2_reg <= 1'b0;
            last1_reg  <= 1'b0;
            last2_reg  <= 1'b0;
            rgb2_reg   <= '0;
            out3_reg   <= '0;
        end else begin
            if (en1) begin
                v1_reg     <= pix_fire;
                raw1_reg   <= raw_in;
                match1_reg <= cfg.key_enable && (raw_in == cfg.key_color);
                last1_reg  <= s_data.last_in;
            end
            if (en2) begin
                v2_reg     <= v1_reg;
                raw2_reg   <= raw1_reg;
                match2_reg <= match1_reg;
                last2_reg  <= last1_reg;
                rgb2_reg   <= rgb_next;
            end
            if (en3) begin
                v3_reg                <= v2_reg;
                out3_reg.out_pixel    <= match2_reg ? 32'd0 : res_next;
                out3_reg.write_enable <= !match2_reg;
                out3_reg.last_out     <= last2_reg;
            end
        end
    end

    assign m_valid = v3_reg;
    assign m_data  = out3_reg;

endmodule

/* rtl/ckpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ckpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ckpc_cfg.sv */
// APB configuration register file of the color-keyed converter.
module ckpc_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ckpc_pkg::APB_AW-1:0] paddr,
    input  logic [ckpc_pkg::APB_DW-1:0] pwdata,
    output logic [ckpc_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output ckpc_pkg::ckpc_cfg_t       cfg
);
    import ckpc_pkg::*;

    ckpc_cfg_t  cfg_reg;
    ckpc_cfg_t  cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx   = reg_index_t'(paddr[APB_AW-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SRC_DEPTH:  cfg_next.src_depth  = src_depth_t'(pwdata[1:0]);
                REG_DST_DEPTH:  cfg_next.dst_depth  = dst_depth_t'(pwdata[1:0]);
                REG_KEY_ENABLE: cfg_next.key_enable = pwdata[0];
                REG_KEY_COLOR:  cfg_next.key_color  = pwdata;
                REG_COPY_INDEX: cfg_next.copy_index = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_SRC_DEPTH:  prdata = {30'd0, cfg_reg.src_depth};
            REG_DST_DEPTH:  prdata = {30'd0, cfg_reg.dst_depth};
            REG_KEY_ENABLE: prdata = {31'd0, cfg_reg.key_enable};
            REG_KEY_COLOR:  prdata = cfg_reg.key_color;
            REG_COPY_INDEX: prdata = {31'd0, cfg_reg.copy_index};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the color-keyed pixel converter: random beats, APB setup, in-order check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ckpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ckpc_in_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ckpc_out_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    color_keyed_pixel_converter_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ckpc_in_t    beats_to_send[$];
    ckpc_out_t   pending_results[$];
    ckpc_out_t   exp_beat;
    logic [23:0] pal_shadow[PAL_DEPTH];
    bit          pal_written[PAL_DEPTH];
    src_depth_t  cfg_src  = SRC_IDX8;
    dst_depth_t  cfg_dst  = DST_RGB332;
    logic        cfg_key_on = 1'b0;
    logic [31:0] cfg_key  = '0;
    logic        cfg_copy = 1'b0;
    bit          calm = 1'b0;
    bit          holdoff_go = 1'b0;
    logic        rx_hold = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic ckpc_out_t convert_pixel(input ckpc_in_t b);
        logic [31:0] raw;
        logic [23:0] rgb;
        logic [31:0] res;
        ckpc_out_t   o;
        case (cfg_src)
            SRC_IDX8: begin
                raw = {24'h0, b.pixel_value[7:0]};
                rgb = pal_shadow[b.pixel_value[7:0]];
            end
            SRC_RGB565: begin
                raw = {16'h0, b.pixel_value[15:0]};
                rgb = {raw[15:11], raw[15:13], raw[10:5], raw[10:9], raw[4:0], raw[4:2]};
            end
            SRC_RGB24: begin
                raw = {8'h0, b.pixel_value[23:0]};
                rgb = raw[23:0];
            end
            default: begin
                raw = b.pixel_value;
                rgb = raw[23:0];
            end
        endcase
        case (cfg_dst)
            DST_RGB332: begin
                if (cfg_src == SRC_IDX8 && cfg_copy)
                    res = raw;
                else if (cfg_src == SRC_RGB565)
                    res = {24'h0, raw[15:13], raw[10:8], raw[4:3]};
                else
                    res = {24'h0, rgb[23:21], rgb[15:13], rgb[7:6]};
            end
            DST_RGB565: begin
                if (cfg_src == SRC_RGB565)
                    res = raw;
                else
                    res = {16'h0, rgb[23:19], rgb[15:10], rgb[7:3]};
            end
            DST_RGB24: res = {8'h0, rgb};
            default:   res = (cfg_src == SRC_RGB32) ? raw : {8'h0, rgb};
        endcase
        if (cfg_key_on && raw == cfg_key) begin
            o.out_pixel    = '0;
            o.write_enable = 1'b0;
        end else begin
            o.out_pixel    = res;
            o.write_enable = 1'b1;
        end
        o.last_out = b.last_in;
        return o;
    endfunction

    // driver: advance to the next beat once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                if (s_data.kind == KIND_PAL_WR)
                    pal_shadow[s_data.pal_index] = s_data.pal_color;
                else
                    pending_results.push_back(convert_pixel(s_data));
            end
            if (beats_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_data  <= beats_to_send.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin : rx_holdoff
        wait (holdoff_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result beat: pixel %h we %b last %b",
                             m_data.out_pixel, m_data.write_enable, m_data.last_out);
                fail_count++;
            end else begin
                exp_beat = pending_results.pop_front();
                if (m_data.out_pixel !== exp_beat.out_pixel ||
                    m_data.write_enable !== exp_beat.write_enable ||
                    m_data.last_out !== exp_beat.last_out) begin
                    if (fail_count < 10)
                        $display("mismatch: expected pixel %h we %b last %b, got pixel %h we %b last %b",
                                 exp_beat.out_pixel, exp_beat.write_enable, exp_beat.last_out,
                                 m_data.out_pixel, m_data.write_enable, m_data.last_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input src_depth_t src, input dst_depth_t dst, input logic key_on,
                              input logic [31:0] key, input logic copy);
        apb_write(REG_SRC_DEPTH, {30'h0, src});
        apb_write(REG_DST_DEPTH, {30'h0, dst});
        apb_write(REG_KEY_ENABLE, {31'h0, key_on});
        apb_write(REG_KEY_COLOR, key);
        apb_write(REG_COPY_INDEX, {31'h0, copy});
        cfg_src    = src;
        cfg_dst    = dst;
        cfg_key_on = key_on;
        cfg_key    = key;
        cfg_copy   = copy;
    endtask

    task automatic push_pal(input logic [7:0] idx, input logic [23:0] color);
        ckpc_in_t b;
        b.kind        = KIND_PAL_WR;
        b.pixel_value = $urandom;
        b.pal_index   = idx;
        b.pal_color   = color;
        b.last_in     = 1'($urandom_range(0, 1));
        pal_written[idx] = 1'b1;
        beats_to_send.push_back(b);
    endtask

    task automatic push_pixel(input logic [31:0] pv);
        ckpc_in_t b;
        if (cfg_src == SRC_IDX8 && !pal_written[pv[7:0]])
            push_pal(pv[7:0], 24'($urandom));
        b.kind        = KIND_PIXEL;
        b.pixel_value = pv;
        b.pal_index   = 8'($urandom);
        b.pal_color   = 24'($urandom);
        b.last_in     = ($urandom_range(0, 7) == 0);
        beats_to_send.push_back(b);
    endtask

    // drain: wait until every beat is sent and every result is back
    task automatic drain();
        while (beats_to_send.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin : stimulus
        src_depth_t  src;
        dst_depth_t  dst;
        logic        key_on;
        logic        copy;
        logic [31:0] key;
        logic [31:0] mask;
        logic [31:0] pv;
        int          sel;

        wait (aresetn);
        @(posedge aclk);

        set_config(SRC_IDX8, DST_RGB332, 1'b0, 32'h0, 1'b0);
        push_pal(8'h00, 24'h000000);
        push_pal(8'hFF, 24'hFFFFFF);
        push_pal(8'h5A, 24'h123456);
        push_pixel(32'hFFFF_FF00);
        push_pixel(32'h0000_00FF);
        push_pixel(32'h0000_005A);
        drain();

        set_config(SRC_IDX8, DST_RGB332, 1'b1, 32'h0000_005A, 1'b1);
        push_pixel(32'hFFFF_FF5A);
        push_pixel(32'h0000_00FF);
        drain();

        // key wider than the source never matches
        set_config(SRC_RGB565, DST_RGB32, 1'b1, 32'h0001_F800, 1'b0);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0001_F800);
        push_pixel(32'h0000_0000);
        drain();

        set_config(SRC_RGB24, DST_RGB565, 1'b1, 32'h00FF_FFFF, 1'b0);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0000_0000);
        drain();

        set_config(SRC_RGB32, DST_RGB32, 1'b1, 32'hFFFF_FFFF, 1'b0);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'hFF00_0000);
        push_pixel(32'h00FF_FFFF);
        drain();

        for (int p = 0; p < 24; p++) begin
            src = src_depth_t'(p % 4);
            dst = dst_depth_t'((p / 4) % 4);
            case (src)
                SRC_IDX8:   mask = 32'h0000_00FF;
                SRC_RGB565: mask = 32'h0000_FFFF;
                SRC_RGB24:  mask = 32'h00FF_FFFF;
                default:    mask = 32'hFFFF_FFFF;
            endcase
            key_on = (p >= 16) || ($urandom_range(0, 1) == 1);
            copy   = 1'($urandom_range(0, 1));
            if (p == 16)
                key = 32'h0;
            else if (p == 17)
                key = 32'hFFFF_FFFF;
            else if ($urandom_range(0, 3) == 0)
                key = $urandom;
            else
                key = $urandom & mask;
            set_config(src, dst, key_on, key, copy);
            calm = (p == 5);
            if (p == 9)
                holdoff_go = 1'b1;
            for (int i = 0; i < 52; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 15) begin
                    push_pal(8'($urandom), 24'($urandom));
                end else begin
                    if (key_on && sel < 40)
                        pv = (key & mask) | ($urandom & ~mask);
                    else if (sel < 45)
                        pv = 32'h0;
                    else if (sel < 50)
                        pv = 32'hFFFF_FFFF;
                    else
                        pv = $urandom;
                    push_pixel(pv);
                end
            end
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ckpc_pkg.sv
rtl/ckpc_ram.sv
rtl/ckpc_cfg.sv
rtl/color_keyed_pixel_converter_top.sv
bench/tb_top.sv
